@@ src/lzd_pkg.sv @@
// lzd_pkg: shared types and constants for the LZ10 stream decoder.
// No dependencies; imported by the interfaces, lzd_ctrl, lzd_datapath, the top level and the bench.
`timescale 1ns / 1ps

package lzd_pkg;

	localparam int unsigned CFG_W  = 24;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned DIST_W = 13;
	localparam int unsigned MLEN_W = 5;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_BYTE      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FINAL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DIST      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_OVERRUN   = 3'd4;

	// parser phase codes
	localparam logic [1:0] PH_FLAG  = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_TAIL  = 2'd2;

	localparam logic [3:0]        FLAG_TOKENS = 4'd8;
	localparam logic [MLEN_W-1:0] LEN_BIAS    = 5'd3;

	// what the current input byte means to the parser
	typedef enum logic [2:0] {
		TK_NONE,
		TK_FLAG,
		TK_LIT,
		TK_HEAD,
		TK_DIST_ERR,
		TK_LEN_ERR,
		TK_COPY
	} tok_kind_t;

	typedef enum logic [1:0] {
		EM_IN,
		EM_MEM,
		EM_ERR
	} emit_sel_t;

	typedef struct packed {
		logic              take;
		logic              restart;
		logic              emit;
		emit_sel_t         emit_sel;
		logic [STAT_W-1:0] err_code;
		logic              run_end;
		logic              copy_start;
		logic              copy_step;
		logic              token_next;
	} ctrl_cmd_t;

	typedef struct packed {
		tok_kind_t kind;
		logic      out_free;
		logic      byte_final;
		logic      copy_last;
		logic      last_q;
	} dp_status_t;

endpackage

@@ src/lzd_in_if.sv @@
// lzd_in_if: compressed byte channel (valid/ready plus payload).
// Depends on lzd_pkg for field widths.
`timescale 1ns / 1ps

interface lzd_in_if import lzd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ src/lzd_out_if.sv @@
// lzd_out_if: decoded result channel (valid/ready plus payload).
// Depends on lzd_pkg for field widths.
`timescale 1ns / 1ps

interface lzd_out_if import lzd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [STAT_W-1:0] status;
	logic              run_end;

	modport source (output valid, output out_byte, output status, output run_end, input ready);
	modport sink   (input valid, input out_byte, input status, input run_end, output ready);
endinterface

@@ src/lzd_ram.sv @@
// lzd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/lzd_ctrl.sv @@
// lzd_ctrl: sequencing state machine of the LZ10 decoder.
// Depends on lzd_pkg; drives lzd_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module lzd_ctrl import lzd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_COPY = 3'b010,
		S_ERR2 = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.take       = 1'b0;
		cmd.restart    = 1'b0;
		cmd.emit       = 1'b0;
		cmd.emit_sel   = EM_ERR;
		cmd.err_code   = STAT_EXHAUSTED;
		cmd.run_end    = 1'b1;
		cmd.copy_start = 1'b0;
		cmd.copy_step  = 1'b0;
		cmd.token_next = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = st.out_free;
				if (in_valid && st.out_free) begin
					cmd.take    = 1'b1;
					cmd.restart = in_last;
					case (st.kind)
						TK_FLAG, TK_HEAD: begin
							cmd.emit = in_last;
						end
						TK_LIT: begin
							cmd.emit     = 1'b1;
							cmd.emit_sel = EM_IN;
							// early end after a non-final literal: error follows
							if (in_last && !st.byte_final) begin
								cmd.run_end = 1'b0;
								state_d     = S_ERR2;
							end
						end
						TK_DIST_ERR: begin
							cmd.emit     = 1'b1;
							cmd.err_code = STAT_DIST;
						end
						TK_LEN_ERR: begin
							cmd.emit     = 1'b1;
							cmd.err_code = STAT_OVERRUN;
						end
						TK_COPY: begin
							cmd.restart    = 1'b0;
							cmd.copy_start = 1'b1;
							state_d        = S_COPY;
						end
						default: begin
						end
					endcase
				end
			end
			S_COPY: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_MEM;
					if (st.copy_last) begin
						cmd.token_next = 1'b1;
						cmd.restart    = st.last_q;
						if (st.last_q && !st.byte_final) begin
							cmd.run_end = 1'b0;
							state_d     = S_ERR2;
						end else begin
							state_d = S_IDLE;
						end
					end else begin
						cmd.run_end   = 1'b0;
						cmd.copy_step = 1'b1;
					end
				end
			end
			S_ERR2: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/lzd_datapath.sv @@
// lzd_datapath: parser state, history window, match copy and result register.
// Depends on lzd_pkg and lzd_ram; commanded by lzd_ctrl.
`timescale 1ns / 1ps

module lzd_datapath import lzd_pkg::*; #(
	parameter int unsigned WINDOW_BYTES = 4096,
	parameter int unsigned COUNT_BITS   = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic [STAT_W-1:0] status,
	output logic              run_end
);

	localparam int unsigned AW    = $clog2(WINDOW_BYTES);
	localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [AW-1:0]    ADDR_TOP = AW'(WINDOW_BYTES - 1);
	localparam logic [AW:0]      WIN_EXT  = (AW+1)'(WINDOW_BYTES);

	logic [CFG_W-1:0]      len_q;
	logic [COUNT_BITS-1:0] produced_q;
	logic [BYTE_W-1:0]     flags_q;
	logic [3:0]            tokens_q;
	logic [1:0]            phase_q;
	logic [BYTE_W-1:0]     head_q;
	logic                  stopped_q;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         raddr_q;
	logic [MLEN_W-1:0]     count_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic [STAT_W-1:0]     out_stat_q;
	logic                  out_end_q;
	logic                  fwd_q;
	logic [BYTE_W-1:0]     fwd_data_q;

	logic [CMP_W-1:0]      len_ext;
	logic [COUNT_BITS-1:0] len_eff;
	logic                  running;
	logic [DIST_W-1:0]     match_dist;
	logic [MLEN_W-1:0]     mlen;
	logic [COUNT_BITS-1:0] remain;
	logic [COUNT_BITS-1:0] produced_nx;
	logic                  byte_final;
	tok_kind_t             kind;
	logic [AW:0]           wp_ext;
	logic [AW:0]           dist_ext;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         raddr_inc;
	logic [AW-1:0]         wp_inc;
	logic [3:0]            tokens_dec;
	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [BYTE_W-1:0]     ram_rdata;
	logic [BYTE_W-1:0]     mem_byte;
	logic [BYTE_W-1:0]     byte_val;
	logic                  out_free;
	logic                  byte_emit;

	// effective length saturates to the counter range
	assign len_ext = CMP_W'(len_q);
	assign len_eff = COUNT_BITS'((len_ext > CNT_MAX) ? CNT_MAX : len_ext);
	assign running = !stopped_q && (produced_q < len_eff);

	assign match_dist  = DIST_W'({head_q[3:0], in_byte}) + DIST_W'(1);
	assign mlen        = MLEN_W'(head_q[7:4]) + LEN_BIAS;
	assign remain      = len_eff - produced_q;
	assign produced_nx = produced_q + COUNT_BITS'(1);
	assign byte_final  = produced_nx >= len_eff;

	always_comb begin
		kind = TK_NONE;
		if (running) begin
			case (phase_q)
				PH_TOKEN: kind = flags_q[7] ? TK_HEAD : TK_LIT;
				PH_TAIL: begin
					if (COUNT_BITS'(match_dist) > produced_q) begin
						kind = TK_DIST_ERR;
					end else if (COUNT_BITS'(mlen) > remain) begin
						kind = TK_LEN_ERR;
					end else begin
						kind = TK_COPY;
					end
				end
				default: kind = TK_FLAG;
			endcase
		end
	end

	// match source address, wrapped into the window
	assign wp_ext   = {1'b0, wp_q};
	assign dist_ext = (AW+1)'(match_dist);
	assign rd_addr  = (wp_ext >= dist_ext) ? AW'(wp_ext - dist_ext)
	                                       : AW'(wp_ext + WIN_EXT - dist_ext);
	assign raddr_inc  = (raddr_q == ADDR_TOP) ? '0 : raddr_q + AW'(1);
	assign wp_inc     = (wp_q == ADDR_TOP) ? '0 : wp_q + AW'(1);
	assign tokens_dec = tokens_q - 4'd1;

	assign byte_emit = cmd.emit && (cmd.emit_sel != EM_ERR);
	assign mem_byte  = fwd_q ? fwd_data_q : ram_rdata;
	assign byte_val  = (cmd.emit_sel == EM_MEM) ? mem_byte : in_byte;
	assign ram_we    = byte_emit;
	assign ram_re    = cmd.copy_start || cmd.copy_step;
	assign ram_raddr = cmd.copy_start ? rd_addr : raddr_inc;

	lzd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (WINDOW_BYTES)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (byte_val),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			produced_q  <= '0;
			flags_q     <= '0;
			tokens_q    <= '0;
			phase_q     <= PH_FLAG;
			head_q      <= '0;
			stopped_q   <= 1'b0;
			wp_q        <= '0;
			raddr_q     <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.take) begin
				last_q <= in_last;
				case (kind)
					TK_NONE, TK_DIST_ERR, TK_LEN_ERR: stopped_q <= 1'b1;
					TK_FLAG: begin
						flags_q  <= in_byte;
						tokens_q <= FLAG_TOKENS;
						phase_q  <= PH_TOKEN;
					end
					TK_LIT: begin
						flags_q  <= {flags_q[6:0], 1'b0};
						tokens_q <= tokens_dec;
						phase_q  <= (tokens_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
					end
					TK_HEAD: begin
						head_q  <= in_byte;
						phase_q <= PH_TAIL;
					end
					TK_COPY: begin
						count_q <= mlen;
					end
					default: begin
					end
				endcase
			end
			if (cmd.token_next) begin
				flags_q  <= {flags_q[6:0], 1'b0};
				tokens_q <= tokens_dec;
				phase_q  <= (tokens_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
			end
			if (ram_re) begin
				raddr_q <= ram_raddr;
				// read of the byte being written this cycle: forward it
				fwd_q   <= ram_we && (wp_q == ram_raddr);
			end
			if (cmd.copy_step) begin
				count_q <= count_q - MLEN_W'(1);
			end
			if (byte_emit) begin
				wp_q       <= wp_inc;
				produced_q <= produced_nx;
				if (byte_final) begin
					stopped_q <= 1'b1;
				end
			end
			if (cmd.restart) begin
				produced_q <= '0;
				flags_q    <= '0;
				tokens_q   <= '0;
				phase_q    <= PH_FLAG;
				head_q     <= '0;
				stopped_q  <= 1'b0;
				wp_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			fwd_data_q <= byte_val;
		end
		if (cmd.emit) begin
			out_end_q <= cmd.run_end;
			if (byte_emit) begin
				out_byte_q <= byte_val;
				out_stat_q <= byte_final ? STAT_FINAL : STAT_BYTE;
			end else begin
				out_byte_q <= '0;
				out_stat_q <= cmd.err_code;
			end
		end
	end

	assign st.kind       = kind;
	assign st.out_free   = out_free;
	assign st.byte_final = byte_final;
	assign st.copy_last  = (count_q == MLEN_W'(1));
	assign st.last_q     = last_q;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = out_stat_q;
	assign run_end   = out_end_q;

endmodule

@@ src/lz10_stream_decoder.sv @@
// lz10_stream_decoder: top level of the streaming LZ10 decompressor.
// Depends on lzd_pkg, lzd_in_if, lzd_out_if, lzd_ctrl, lzd_datapath, lzd_ram.
`timescale 1ns / 1ps

// Streaming LZ10 decoder. Compressed bytes arrive one transfer at a time on
// src, with in_last marking the final source byte; results leave on dst as
// (out_byte, status, run_end), run_end flagging the last result of each input
// transfer. A match tail byte starts a copy that emits one byte per cycle
// (3 to 18 bytes), paced by the single read port of the history RAM; an early
// end of source after a literal or match adds one more result, of status 2.
// Output back-pressure stalls the copy and any result. The user must write
// output_length through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this. The history window needs no
// clearing pass after reset: a match can only reach bytes written earlier in
// the same stream.
module lz10_stream_decoder import lzd_pkg::*; #(
	parameter int unsigned WINDOW_BYTES = 4096,
	parameter int unsigned COUNT_BITS   = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	lzd_in_if.sink           src,
	lzd_out_if.source        dst
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	// controller: accepts a transfer only when the result register can take
	// the first result, and steps the match copy one byte per cycle while that register is free
	lzd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (src.valid),
		.in_last  (src.in_last),
		.in_ready (src.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: parser state, history window, copy address and the
	// output register that decouples dst from src
	lzd_datapath #(
		.WINDOW_BYTES (WINDOW_BYTES),
		.COUNT_BITS   (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_byte     (src.in_byte),
		.in_last     (src.in_last),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (dst.valid),
		.out_ready   (dst.ready),
		.out_byte    (dst.out_byte),
		.status      (dst.status),
		.run_end     (dst.run_end)
	);

endmodule

@@ tb/sv/tb_lz10_stream_decoder.sv @@
// tb_lz10_stream_decoder: self-checking bench for the LZ10 stream decoder.
// Depends on lzd_pkg, lzd_in_if, lzd_out_if and lz10_stream_decoder; a built-in
// decode model predicts every result, and the bench checks them in order.
`timescale 1ns / 1ps

module tb_lz10_stream_decoder;
	import lzd_pkg::*;

	localparam int IDLE_GAP     = 16;     // quiet cycles before a register write
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int STALL_LIMIT  = 4000;   // cycles without any transfer
	localparam int RANDOM_ITEMS = 180;
	localparam int LONG_LEN     = 600;    // long match-heavy stream for the hold-off
	localparam int WIN_BYTES    = 4096;
	localparam int MAX_REPORTS  = 40;
	localparam logic [CFG_W-1:0] LEN_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} src_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [STAT_W-1:0] status;
		logic              run_end;
	} result_t;

	typedef enum logic [1:0] {DEC_RUN, DEC_DONE, DEC_ERR} dec_state_t;
	typedef enum logic [1:0] {FLAW_NONE, FLAW_FAR, FLAW_OVERRUN} flaw_t;
	typedef enum logic [1:0] {PACE_FULL, PACE_SRC_GAPS, PACE_DST_STALL, PACE_BOTH} pace_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             hold_rx;

	lzd_in_if  src_if ();
	lzd_out_if dst_if ();

	lz10_stream_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.src         (src_if),
		.dst         (dst_if)
	);

	// ---------------------------------------------------------------------
	// Decode model state: the bench's own copy of the history window,
	// parser and output counter, plus the length register as last written.
	// ---------------------------------------------------------------------
	logic [BYTE_W-1:0] win_mem [WIN_BYTES];
	logic [11:0]       wr_ptr;
	logic [CFG_W-1:0]  out_count;
	logic [CFG_W-1:0]  out_len_cfg;
	logic [7:0]        flag_reg;
	logic [3:0]        tok_left;
	logic [1:0]        parse_phase;
	logic [7:0]        head_byte;
	dec_state_t        dec_st;

	src_item_t source_q [$];     // compressed bytes not yet transferred
	result_t   decoded_q [$];    // predicted results, oldest first
	src_item_t stream_buf [$];   // one generated stream before queuing

	int src_idle_pct;
	int dst_stall_pct;
	int fail_count;
	int issued;
	int quiet_cycles;

	task automatic restart_decode();
		out_count   = '0;
		flag_reg    = '0;
		tok_left    = '0;
		parse_phase = PH_FLAG;
		head_byte   = '0;
		dec_st      = DEC_RUN;
		wr_ptr      = '0;
	endtask

	// one decoded byte into history; the byte that reaches the length is final
	task automatic emit_out(input logic [BYTE_W-1:0] b);
		win_mem[wr_ptr] = b;
		wr_ptr    = wr_ptr + 1'b1;
		out_count = out_count + 1'b1;
		if (out_count >= out_len_cfg) begin
			decoded_q.push_back('{b, STAT_FINAL, 1'b0});
			dec_st = DEC_DONE;
		end else begin
			decoded_q.push_back('{b, STAT_BYTE, 1'b0});
		end
	endtask

	task automatic next_token();
		flag_reg    = flag_reg << 1;
		tok_left    = tok_left - 1'b1;
		parse_phase = (tok_left != 0) ? PH_TOKEN : PH_FLAG;
	endtask

	// Expected results for one compressed byte.
	task automatic decode_step(input logic [BYTE_W-1:0] b, input logic fin);
		logic [DIST_W-1:0] reach;
		logic [MLEN_W-1:0] mlen;
		logic [11:0]       rd;
		int                n_before;
		int                i;
		n_before = decoded_q.size();
		// length may have been lowered to or below what is already out
		if (dec_st == DEC_RUN && out_count >= out_len_cfg)
			dec_st = DEC_DONE;
		if (dec_st == DEC_RUN) begin
			case (parse_phase)
				PH_TOKEN: begin
					if (flag_reg[7]) begin
						head_byte   = b;
						parse_phase = PH_TAIL;
					end else begin
						emit_out(b);
						next_token();
					end
				end
				PH_TAIL: begin
					reach = {1'b0, head_byte[3:0], b} + 1'b1;
					mlen  = {1'b0, head_byte[7:4]} + LEN_BIAS;
					// distance is checked before length
					if (reach > out_count) begin
						decoded_q.push_back('{'0, STAT_DIST, 1'b0});
						dec_st = DEC_ERR;
					end else if (mlen > out_len_cfg - out_count) begin
						decoded_q.push_back('{'0, STAT_OVERRUN, 1'b0});
						dec_st = DEC_ERR;
					end else begin
						for (i = 0; i < mlen; i++) begin
							rd = wr_ptr - reach[11:0];
							emit_out(win_mem[rd]);
						end
						next_token();
					end
				end
				default: begin
					flag_reg    = b;
					tok_left    = FLAG_TOKENS;
					parse_phase = PH_TOKEN;
				end
			endcase
			// source ran out before the output was complete
			if (fin && dec_st == DEC_RUN) begin
				decoded_q.push_back('{'0, STAT_EXHAUSTED, 1'b0});
				dec_st = DEC_ERR;
			end
		end
		if (decoded_q.size() > n_before)
			decoded_q[decoded_q.size() - 1].run_end = 1'b1;
		if (fin)
			restart_decode();
	endtask

	task automatic check_result();
		result_t want;
		if (decoded_q.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("result with nothing pending: out_byte %0h status %0d run_end %0b",
					dst_if.out_byte, dst_if.status, dst_if.run_end);
		end else begin
			want = decoded_q.pop_front();
			if (dst_if.out_byte !== want.data) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("out_byte: expected %0h, got %0h", want.data, dst_if.out_byte);
			end
			if (dst_if.status !== want.status) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("status: expected %0d, got %0d", want.status, dst_if.status);
			end
			if (dst_if.run_end !== want.run_end) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("run_end: expected %0b, got %0b", want.run_end, dst_if.run_end);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Clock and reset. Every input gets a known value at time zero.
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		hold_rx        = 1'b0;
		src_if.valid   = 1'b0;
		src_if.in_byte = '0;
		src_if.in_last = 1'b0;
		dst_if.ready   = 1'b0;
		src_idle_pct   = 0;
		dst_stall_pct  = 0;
		fail_count     = 0;
		issued         = 0;
		out_len_cfg    = '0;
		restart_decode();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------------
	// Source driver: offers the head of source_q, holds it until the
	// transfer, and predicts the results at the transfer edge.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_if.valid   <= 1'b0;
			src_if.in_byte <= '0;
			src_if.in_last <= 1'b0;
		end else begin
			if (src_if.valid && src_if.ready) begin
				decode_step(src_if.in_byte, src_if.in_last);
				void'(source_q.pop_front());
			end
			// only change the offer when nothing is held
			if (!src_if.valid || src_if.ready) begin
				if (source_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					src_if.valid   <= 1'b1;
					src_if.in_byte <= source_q[0].data;
					src_if.in_last <= source_q[0].last;
				end else begin
					src_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random stalls, plus the long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_if.ready <= 1'b0;
		end else begin
			if (dst_if.valid && dst_if.ready)
				check_result();
			dst_if.ready <= !hold_rx && ($urandom_range(99) >= dst_stall_pct);
		end
	end

	// Watchdog: a run with no transfer on either side for too long is hung.
	always @(posedge clk) begin
		if (!arst_n || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("** lz10_stream_decoder: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic wait_drained();
		@(negedge clk);
		while (source_q.size() != 0 || decoded_q.size() != 0)
			@(negedge clk);
	endtask

	// register write only when idle; the gap covers bytes that give no result
	task automatic set_length(input logic [CFG_W-1:0] v);
		wait_drained();
		repeat (IDLE_GAP) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		out_len_cfg = v;
	endtask

	task automatic set_pacing(input pace_t p);
		case (p)
			PACE_SRC_GAPS: begin
				src_idle_pct  = 74;
				dst_stall_pct = 0;
			end
			PACE_DST_STALL: begin
				src_idle_pct  = 0;
				dst_stall_pct = 74;
			end
			PACE_BOTH: begin
				src_idle_pct  = 33;
				dst_stall_pct = 33;
			end
			default: begin
				src_idle_pct  = 0;
				dst_stall_pct = 0;
			end
		endcase
	endtask

	task automatic put(input logic [7:0] b, input logic fin);
		source_q.push_back('{b, fin});
	endtask

	task automatic start_hold();
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
	endtask

	// Builds a well-formed stream of n_out output bytes into stream_buf.
	// Matches only reach bytes already produced; a flaw ends the stream
	// early with a bad match (distance past the start, or too long).
	task automatic gen_stream(input int n_out, input flaw_t flaw, input int match_pct);
		int         made;
		int         remain;
		int         mlen;
		int         back;
		int         far_lim;
		int         t;
		bit         stop;
		bit         bad;
		logic [7:0] flag;
		logic [7:0] body [$];
		stream_buf.delete();
		made = 0;
		stop = 1'b0;
		while (!stop && made < n_out) begin
			flag = 8'($urandom);   // bits past the end stay random
			body.delete();
			for (t = 0; t < 8 && !stop && made < n_out; t++) begin
				remain = n_out - made;
				bad = 1'b0;
				if (flaw == FLAW_FAR)
					bad = (remain <= 2) || ($urandom_range(5) == 0);
				else if (flaw == FLAW_OVERRUN)
					bad = (remain <= 2) || (remain < 18 && $urandom_range(1) == 0);
				if (bad) begin
					flag[7-t] = 1'b1;
					if (flaw == FLAW_FAR) begin
						back = $urandom_range(1) ? made + 1 : $urandom_range(made + 1, WIN_BYTES);
						mlen = $urandom_range(3, 18);
					end else begin
						mlen = $urandom_range(remain + 1, 18);
						back = (made == 0) ? 1 : $urandom_range(1, made);
					end
					body.push_back(8'(((mlen - 3) << 4) | ((back - 1) >> 8)));
					body.push_back(8'(back - 1));
					stop = 1'b1;
				end else if (made >= 1 && remain >= 3 && $urandom_range(99) < match_pct) begin
					flag[7-t] = 1'b1;
					mlen    = $urandom_range(3, (remain < 18) ? remain : 18);
					far_lim = (made < WIN_BYTES) ? made : WIN_BYTES;
					back    = ($urandom_range(3) == 0) ? far_lim : $urandom_range(1, far_lim);
					body.push_back(8'(((mlen - 3) << 4) | ((back - 1) >> 8)));
					body.push_back(8'(back - 1));
					made += mlen;
				end else begin
					flag[7-t] = 1'b0;
					body.push_back(8'($urandom));
					made++;
				end
			end
			stream_buf.push_back('{flag, 1'b0});
			foreach (body[i])
				stream_buf.push_back('{body[i], 1'b0});
		end
	endtask

	// Queues stream_buf: optional truncation, trailing junk, last mark on
	// the final byte. A split drains all results mid-stream and may lower
	// the length to one byte at that point.
	task automatic queue_stream(input bit cut, input int junk, input int split, input bit lower);
		int keep;
		if (cut && stream_buf.size() > 1) begin
			keep = $urandom_range(1, stream_buf.size() - 1);
			while (stream_buf.size() > keep)
				void'(stream_buf.pop_back());
		end
		repeat (junk) stream_buf.push_back('{8'($urandom), 1'b0});
		stream_buf[stream_buf.size() - 1].last = 1'b1;
		foreach (stream_buf[i]) begin
			if (split != 0 && i == split) begin
				wait_drained();
				if (lower)
					set_length(CFG_W'(1));
			end
			source_q.push_back(stream_buf[i]);
		end
		issued += stream_buf.size();
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		int pick;
		int nout;
		int batch;
		int split;
		logic [CFG_W-1:0] blen;

		wait (arst_n === 1'b1);
		set_pacing(PACE_FULL);

		// zero length: everything ignored up to the last-marked byte
		set_length(CFG_W'(0));
		put(8'hFF, 1'b0);
		put(8'h00, 1'b1);

		// literals 00/FF, short match, literal, match that lands exactly on
		// the length, then a trailing byte after completion
		set_length(CFG_W'(16));
		put(8'h28, 1'b0);
		put(8'h00, 1'b0);
		put(8'hFF, 1'b0);
		put(8'h00, 1'b0);
		put(8'h01, 1'b0);
		put(8'hA5, 1'b0);
		put(8'h70, 1'b0);
		put(8'h05, 1'b0);
		put(8'h5A, 1'b1);

		// largest length: early end after a literal, distance past the start
		// (longest match, farthest reach), early end on a bare flag byte
		set_length(LEN_MAX);
		put(8'h00, 1'b0);
		put(8'h11, 1'b1);
		put(8'h80, 1'b0);
		put(8'hFF, 1'b0);
		put(8'hFF, 1'b0);
		put(8'h33, 1'b1);
		put(8'h00, 1'b1);

		// match longer than the bytes still expected
		set_length(CFG_W'(4));
		put(8'h40, 1'b0);
		put(8'h01, 1'b0);
		put(8'h10, 1'b0);
		put(8'h00, 1'b0);
		put(8'h77, 1'b1);

		// random batches: one length per batch, several streams back to back
		issued = 0;
		batch  = 0;
		while (issued < RANDOM_ITEMS) begin
			pick = $urandom_range(9);
			if (pick == 0)
				blen = '0;
			else if (pick == 1)
				blen = LEN_MAX;
			else
				blen = CFG_W'($urandom_range(1, 64));
			set_length(blen);
			set_pacing(pace_t'(batch % 4));
			repeat ($urandom_range(2, 5)) begin
				pick = $urandom_range(99);
				if (out_len_cfg == 0 || out_len_cfg == LEN_MAX)
					nout = $urandom_range(1, 40);
				else
					nout = int'(out_len_cfg);
				if (pick < 50) begin
					gen_stream(nout, FLAW_NONE, 40);
					queue_stream(1'b0, (pick < 15) ? $urandom_range(1, 3) : 0, 0, 1'b0);
				end else if (pick < 65) begin
					gen_stream(nout, FLAW_NONE, 40);
					queue_stream(1'b1, 0, 0, 1'b0);
				end else if (pick < 75) begin
					gen_stream(nout, FLAW_FAR, 40);
					queue_stream(1'b0, $urandom_range(0, 2), 0, 1'b0);
				end else if (pick < 85) begin
					gen_stream(nout, FLAW_OVERRUN, 40);
					queue_stream(1'b0, $urandom_range(0, 2), 0, 1'b0);
				end else begin
					// sender pauses mid-stream until all results are out
					gen_stream(nout, FLAW_NONE, 40);
					split = (stream_buf.size() >= 3) ? $urandom_range(2, stream_buf.size() - 1) : 0;
					queue_stream(1'b0, 0, split, $urandom_range(2) == 0);
				end
			end
			batch++;
		end

		// long stream, mostly matches, with the receiver held off so the
		// decoder backs up into its input
		set_length(CFG_W'(LONG_LEN));
		set_pacing(PACE_FULL);
		gen_stream(LONG_LEN, FLAW_NONE, 95);
		queue_stream(1'b0, 0, 0, 1'b0);
		start_hold();

		wait_drained();
		repeat (IDLE_GAP) @(posedge clk);
		if (fail_count == 0)
			$display("** lz10_stream_decoder: PASSED **");
		else
			$display("** lz10_stream_decoder: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
src/lzd_pkg.sv
src/lzd_in_if.sv
src/lzd_out_if.sv
src/lzd_ram.sv
src/lzd_ctrl.sv
src/lzd_datapath.sv
src/lz10_stream_decoder.sv
tb/sv/tb_lz10_stream_decoder.sv
